// File: hw/rtl/lzss_pkg.sv
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared constants, beat types and the control state type of the decoder.
// ----------------------------------------------------------------------------
package lzss_pkg;

   // Window geometry and the first write slot of a stream.
   localparam int WINDOW_SIZE_DEF = 4096;
   localparam int START_POS_DEF   = 4078;

   // A match copies (low nibble + 3) bytes, so at most 18.
   localparam int MATCH_BIAS = 3;
   localparam int LEN_W      = 5;

   // Input beat: one compressed byte and the end-of-stream mark.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // Output beat: one decompressed byte and the last-of-run mark.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_type;

   // Decoder control: take input bytes, or copy a match out of the window.
   typedef enum logic {
      ST_IDLE,
      ST_COPY
   } state_type;

endpackage

// File: hw/rtl/lzss_window_decompressor.sv
// ----------------------------------------------------------------------------
// LZSS window decompressor
// Decodes an LZSS stream with a 4096-byte history window, one input beat at a
// time, and emits the decompressed bytes one beat per cycle while not stalled.
// ----------------------------------------------------------------------------
// A flag byte or the first byte of a match gives no output. A literal gives
// one output beat. The second byte of a match starts a copy of 3 to 18 bytes,
// which are read one per cycle from the single-port-read window memory,
// emitted and written back at the write slot while the output is not stalled.
// Output stalls pause the copy. The window reads as zero after reset and after
// the last byte of each stream: a fill count tracks how many slots have been
// written since, so no clearing pass is needed and the block is ready right
// after reset.
module lzss_window_decompressor
   import lzss_pkg::*;
#(
   parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
   parameter int START_POS   = START_POS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam logic [AW-1:0] START_ADDR = AW'(START_POS);
   localparam logic [AW:0]   FULL_COUNT = (AW+1)'(WINDOW_SIZE);

   // Window memory.
   logic [7:0] history_mem [WINDOW_SIZE];

   // Control and datapath registers.
   state_type      state_ff, state_in;
   logic [AW-1:0]  wr_pos_ff, wr_pos_in;
   logic [AW:0]    fill_ff, fill_in;
   logic [8:0]     flag_ff, flag_in;
   logic           phase_ff, phase_in;
   logic [7:0]     offset_low_ff, offset_low_in;
   logic           last_ff, last_in;
   logic [AW-1:0]  rd_addr_ff, rd_addr_in;
   logic [LEN_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic [LEN_W-1:0] emit_cnt_ff, emit_cnt_in;
   logic           pend_ff, pend_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   // Read data path, captured when a read is issued.
   logic [7:0]     mem_rd_ff;
   logic           fwd_hit_ff;
   logic [7:0]     fwd_data_ff;
   logic           hist_ok_ff;

   // Combinational controls.
   logic           out_free;
   logic           req_accept;
   logic           copy_emit;
   logic           rd_issue;
   logic           mem_we;
   logic [7:0]     mem_wd;
   logic [7:0]     copy_byte;
   logic [AW-1:0]  rd_off;
   logic           rd_in_fill;
   logic           lit_emit;
   logic           match_start;

   // Handshake: the output register is free when empty or being taken.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Byte coming out of the window; unwritten slots read as zero.
   assign copy_byte = fwd_hit_ff ? fwd_data_ff : (hist_ok_ff ? mem_rd_ff : 8'h00);

   // A slot holds stream data if it lies within the run written since the start.
   assign rd_off     = rd_addr_ff - START_ADDR;
   assign rd_in_fill = {1'b0, rd_off} < fill_ff;

   // Decode of the accepted byte.
   assign match_start = req_accept && phase_ff;
   assign lit_emit    = req_accept && !phase_ff && (flag_ff > 9'd1) && flag_ff[0];

   // Copy engine: emit the pending byte and issue the next read.
   assign copy_emit = (state_ff == ST_COPY) && pend_ff && out_free;
   assign rd_issue  = (state_ff == ST_COPY) && (rd_cnt_ff != '0) && (!pend_ff || copy_emit);

   // Window write port: literal or copied byte at the write slot.
   assign mem_we = lit_emit || copy_emit;
   assign mem_wd = lit_emit ? req_data.in_byte : copy_byte;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (match_start) begin
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            if (copy_emit && (emit_cnt_ff == LEN_W'(1))) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and output controls.
   always_comb begin
      wr_pos_in     = wr_pos_ff;
      fill_in       = fill_ff;
      flag_in       = flag_ff;
      phase_in      = phase_ff;
      offset_low_in = offset_low_ff;
      last_in       = last_ff;
      rd_addr_in    = rd_addr_ff;
      rd_cnt_in     = rd_cnt_ff;
      emit_cnt_in   = emit_cnt_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      // Every window write advances the slot and grows the fill count up to the window size.
      if (mem_we) begin
         wr_pos_in = wr_pos_ff + AW'(1);
         if (fill_ff != FULL_COUNT) begin
            fill_in = fill_ff + (AW+1)'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (phase_ff) begin
                  // Second match byte: high position nibble and length.
                  rd_addr_in  = {req_data.in_byte[7:4], offset_low_ff};
                  rd_cnt_in   = LEN_W'(req_data.in_byte[3:0]) + LEN_W'(MATCH_BIAS);
                  emit_cnt_in = LEN_W'(req_data.in_byte[3:0]) + LEN_W'(MATCH_BIAS);
                  pend_in     = 1'b0;
                  last_in     = req_data.in_last;
                  phase_in    = 1'b0;
               end else if (flag_ff <= 9'd1) begin
                  // New flag byte with a marker bit above it.
                  flag_in = {1'b1, req_data.in_byte};
               end else begin
                  flag_in = {1'b0, flag_ff[8:1]};
                  if (flag_ff[0]) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{out_byte: req_data.in_byte, run_last: 1'b1};
                  end else begin
                     offset_low_in = req_data.in_byte;
                     phase_in      = 1'b1;
                  end
               end
               // End of stream on any byte but the second of a match: back to the start state.
               if (req_data.in_last && !phase_ff) begin
                  wr_pos_in     = START_ADDR;
                  fill_in       = '0;
                  flag_in       = '0;
                  phase_in      = 1'b0;
                  offset_low_in = '0;
               end
            end
         end
         ST_COPY: begin
            if (rd_issue) begin
               rd_addr_in = rd_addr_ff + AW'(1);
               rd_cnt_in  = rd_cnt_ff - LEN_W'(1);
            end
            pend_in = rd_issue || (pend_ff && !copy_emit);
            if (copy_emit) begin
               emit_cnt_in  = emit_cnt_ff - LEN_W'(1);
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{out_byte: copy_byte, run_last: emit_cnt_ff == LEN_W'(1)};
               // Match that ends the stream: clear once its last byte is out.
               if ((emit_cnt_ff == LEN_W'(1)) && last_ff) begin
                  wr_pos_in     = START_ADDR;
                  fill_in       = '0;
                  flag_in       = '0;
                  phase_in      = 1'b0;
                  offset_low_in = '0;
                  last_in       = 1'b0;
               end
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_pos_ff     <= START_ADDR;
         fill_ff       <= '0;
         flag_ff       <= '0;
         phase_ff      <= 1'b0;
         offset_low_ff <= '0;
         last_ff       <= 1'b0;
         rd_cnt_ff     <= '0;
         emit_cnt_ff   <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_pos_ff     <= wr_pos_in;
         fill_ff       <= fill_in;
         flag_ff       <= flag_in;
         phase_ff      <= phase_in;
         offset_low_ff <= offset_low_in;
         last_ff       <= last_in;
         rd_cnt_ff     <= rd_cnt_in;
         emit_cnt_ff   <= emit_cnt_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Window memory: one write and one registered read per cycle. A read of
   // the slot written in the same cycle takes the new byte by forwarding.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         history_mem[wr_pos_ff] <= mem_wd;
      end
      if (rd_issue) begin
         mem_rd_ff   <= history_mem[rd_addr_ff];
         fwd_hit_ff  <= mem_we && (wr_pos_ff == rd_addr_ff);
         fwd_data_ff <= mem_wd;
         hist_ok_ff  <= rd_in_fill;
      end
   end

   // Input beats are taken only while no match copy is running.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (state_ff == ST_IDLE))
      else $error("input beat accepted during a match copy");

   // A running copy always has bytes left, and never more reads than bytes.
   a_copy_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> ((emit_cnt_ff != '0) && (rd_cnt_ff <= emit_cnt_ff)))
      else $error("match copy counters out of step");

   // The last copied byte returns the decoder to taking input.
   a_copy_done: assert property (@(posedge clock) disable iff (reset)
      (copy_emit && (emit_cnt_ff == LEN_W'(1))) |=> (state_ff == ST_IDLE) && !pend_ff)
      else $error("match copy did not finish after its last byte");

   // A pending read only exists while copying.
   a_pend_copy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_COPY))
      else $error("window read pending outside a match copy");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZSS window decompressor testbench
// Feeds compressed streams into the decoder through the request channel.
// Every accepted beat is decoded by a local window model, and each output
// beat is compared in order with the bytes that model expects. A short
// directed table comes first. It is followed by random well-formed streams,
// with some noise and cut streams among them, under three idling patterns
// and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import lzss_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int ITEMS_PER_PHASE = 40;

   typedef enum logic {
      EXPECT_CODE,
      EXPECT_MATCH_HI
   } parse_phase_type;

   // Side data that travels with each offered beat to the monitor.
   typedef struct {
      bit      typed;
      rsp_type want;
   } beat_note_type;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Model of the decoder state.
   logic [7:0]      win_mem [WINDOW_SIZE_DEF];
   logic [11:0]     win_wr;
   logic [8:0]      sel_bits;
   parse_phase_type parse_phase;
   logic [7:0]      match_lo;
   rsp_type         step_out[$];

   rsp_type          pending_bytes[$];
   beat_note_type    beat_notes[$];
   directed_row_type directed_rows[$];

   int fail_count     = 0;
   int beats_sent     = 0;
   int send_idle_pct  = 20;
   int recv_stall_pct = 64;
   bit long_hold_req  = 1'b0;
   bit long_hold_done = 1'b0;

   lzss_window_decompressor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Return the window model to its state at the start of a stream.
   function automatic void restart_stream();
      foreach (win_mem[i]) win_mem[i] = 8'h00;
      win_wr      = 12'(START_POS_DEF);
      sel_bits    = 9'd0;
      parse_phase = EXPECT_CODE;
      match_lo    = 8'h00;
   endfunction

   function automatic void append_byte(logic [7:0] b);
      win_mem[win_wr] = b;
      win_wr          = win_wr + 12'd1;
      step_out.push_back({b, 1'b0});
   endfunction

   // Decode one compressed beat into step_out.
   function automatic void decode_beat(req_type beat);
      logic [11:0] pos;
      int          len;
      step_out.delete();
      if (parse_phase == EXPECT_MATCH_HI) begin
         pos = {beat.in_byte[7:4], match_lo};
         len = int'(beat.in_byte[3:0]) + MATCH_BIAS;
         for (int i = 0; i < len; i++) append_byte(win_mem[pos + 12'(i)]);
         parse_phase = EXPECT_CODE;
      end else if (sel_bits <= 9'd1) begin
         sel_bits = {1'b1, beat.in_byte};
      end else begin
         if (sel_bits[0]) begin
            append_byte(beat.in_byte);
         end else begin
            match_lo    = beat.in_byte;
            parse_phase = EXPECT_MATCH_HI;
         end
         sel_bits = sel_bits >> 1;
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
      if (beat.in_last) restart_stream();
   endfunction

   task automatic note_failure(string what, rsp_type want, rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t %s: expected byte %02h last %0b, got byte %02h last %0b",
                  $realtime, what, want.out_byte, want.run_last, got.out_byte, got.run_last);
   endtask

   // Beat monitor: predict on each accepted input, check each accepted output.
   always @(posedge clock) begin : beat_monitor
      beat_note_type note;
      rsp_type       want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            note = beat_notes.pop_front();
            decode_beat(req_data);
            if (note.typed) pending_bytes.push_back(note.want);
            else foreach (step_out[i]) pending_bytes.push_back(step_out[i]);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_bytes.size() == 0) begin
               note_failure("unexpected output beat", '0, rsp_data);
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte || rsp_data.run_last !== want.run_last)
                  note_failure("output mismatch", want, rsp_data);
            end
         end
      end
   end

   // Offer one beat, with random idle cycles ahead of it, and wait for acceptance.
   task automatic offer(req_type beat, bit typed = 1'b0, rsp_type want = '0);
      beat_note_type note;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      note.typed = typed;
      note.want  = want;
      beat_notes.push_back(note);
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic add_row(logic [7:0] b, logic l, bit typed = 1'b0, logic [7:0] want_byte = 8'h00);
      directed_row_type row;
      row.beat  = {b, l};
      row.typed = typed;
      row.want  = {want_byte, 1'b1};
      directed_rows.push_back(row);
   endtask

   // One random well-formed stream. Matches mostly point just behind the
   // write slot so that they overlap fresh data. Some streams are cut short.
   task automatic send_stream();
      int          n_codes;
      int          gen_pos;
      int          len;
      int          ending;
      bit          is_last;
      logic [7:0]  flags;
      logic [11:0] pos;
      n_codes = ($urandom_range(9) == 0) ? $urandom_range(40, 16) : $urandom_range(12, 1);
      ending  = $urandom_range(9);
      gen_pos = START_POS_DEF;
      flags   = 8'h00;
      for (int c = 0; c < n_codes; c++) begin
         if (c % 8 == 0) begin
            flags = 8'($urandom);
            offer({flags, 1'b0});
         end
         is_last = (c == n_codes - 1) && (ending != 1);
         if (flags[c % 8]) begin
            offer({8'($urandom), is_last});
            gen_pos++;
         end else begin
            len = $urandom_range(18, 3);
            if ($urandom_range(9) < 7) pos = 12'(gen_pos - $urandom_range(40, 1));
            else pos = 12'($urandom);
            if (is_last && ending == 0) begin
               // The stream ends after the first match byte.
               offer({pos[7:0], 1'b1});
            end else begin
               offer({pos[7:0], 1'b0});
               offer({pos[11:8], 4'(len - MATCH_BIAS), is_last});
               gen_pos += len;
            end
         end
      end
      // A trailing byte ends the stream on its own.
      if (ending == 1) offer({8'($urandom), 1'b1});
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(8, 1);
      repeat (n) offer({8'($urandom), ($urandom_range(7) == 0)});
   endtask

   // Output side: random stalls, and one long hold-off on request.
   initial begin : rsp_side
      int hold_cycles;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            for (hold_cycles = 0; hold_cycles < HOLD_OFF_CYCLES; hold_cycles++)
               @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin : run_limit
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int phase_goal;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      restart_stream();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Literals carry their output byte; matches are predicted.
      add_row(8'h55, 1'b0);
      add_row(8'h00, 1'b0, 1'b1, 8'h00);
      add_row(8'h00, 1'b0);
      add_row(8'h00, 1'b0);                  // three zeros from the cleared window
      add_row(8'hFF, 1'b0, 1'b1, 8'hFF);
      add_row(8'hEE, 1'b0);
      add_row(8'hFF, 1'b0);                  // longest match, overlapping the write slot
      add_row(8'hA5, 1'b0, 1'b1, 8'hA5);
      add_row(8'hFF, 1'b0);
      add_row(8'hF0, 1'b0);                  // match that wraps past the window end
      add_row(8'h5A, 1'b0, 1'b1, 8'h5A);
      add_row(8'h10, 1'b0);
      add_row(8'h0F, 1'b0);
      add_row(8'hFF, 1'b0);
      add_row(8'h80, 1'b0, 1'b1, 8'h80);
      add_row(8'h7F, 1'b1, 1'b1, 8'h7F);     // literal ends the stream
      add_row(8'h00, 1'b0);
      add_row(8'hEE, 1'b0);
      add_row(8'hF5, 1'b0);                  // window must read zero again
      add_row(8'h34, 1'b1);                  // stream ends inside a match
      add_row(8'h01, 1'b1);                  // flag byte ends the stream
      add_row(8'hFE, 1'b0);
      add_row(8'hEE, 1'b0);
      add_row(8'h02, 1'b1);                  // match ends the stream
      add_row(8'h01, 1'b0);
      add_row(8'h01, 1'b1, 1'b1, 8'h01);
      foreach (directed_rows[i])
         offer(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

      // Random streams under three idling patterns.
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct  = 20;
               recv_stall_pct = 64;
            end
            1: begin
               send_idle_pct  = 64;
               recv_stall_pct = 20;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               long_hold_req  = 1'b1;
            end
         endcase
         phase_goal = beats_sent + ITEMS_PER_PHASE;
         while (beats_sent < phase_goal) begin
            if ($urandom_range(9) == 0) send_noise();
            else send_stream();
         end
      end
      req_valid <= 1'b0;

      // Drain the outputs, then watch for stray beats.
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_bytes.size() != 0) fail_count++;

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
